[rtl/rbd_pkg.sv]
package rbd_pkg;

  localparam int WORD_W = 32;

  typedef enum logic [1:0] {
    KIND_PUSH_FRONT = 2'd0,
    KIND_PUSH_BACK  = 2'd1,
    KIND_POP_FRONT  = 2'd2,
    KIND_POP_BACK   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    kind_t                      kind;
    logic signed [WORD_W-1:0]   value;
  } in_t;

  typedef struct packed {
    status_t                    status;
    logic signed [WORD_W-1:0]   front_value;
    logic signed [WORD_W-1:0]   back_value;
    logic                       is_empty;
    logic                       is_full;
  } out_t;

  // Per-cycle command broadcast to every cell of one chain.
  typedef struct packed {
    logic ins;  // shift toward the tail, new word enters at cell 0
    logic rem;  // shift toward cell 0, word at cell 0 leaves
    logic app;  // new word lands in the cell just past the last occupied one
  } cell_op_t;

endpackage

[rtl/rbd_cell.sv]
module rbd_cell #(
  parameter int LEN_W = 5,
  parameter int INDEX = 0
) (
  input  logic                               clk,
  input  rbd_pkg::cell_op_t                  op,
  input  logic [LEN_W-1:0]                   len,
  input  logic signed [rbd_pkg::WORD_W-1:0]  word,
  input  logic signed [rbd_pkg::WORD_W-1:0]  left_word,
  input  logic signed [rbd_pkg::WORD_W-1:0]  right_word,
  output logic signed [rbd_pkg::WORD_W-1:0]  data
);

  logic signed [rbd_pkg::WORD_W-1:0] data_next;

  always_comb begin
    data_next = data;
    if (op.ins) begin
      data_next = left_word;
    end else if (op.rem) begin
      data_next = right_word;
    end else if (op.app && (len == LEN_W'(INDEX))) begin
      data_next = word;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

[rtl/rbd_chain.sv]
module rbd_chain #(
  parameter int DEPTH = 16,
  parameter int LEN_W = 5
) (
  input  logic                               clk,
  input  rbd_pkg::cell_op_t                  op,
  input  logic [LEN_W-1:0]                   len,
  input  logic signed [rbd_pkg::WORD_W-1:0]  word,
  output logic signed [rbd_pkg::WORD_W-1:0]  head_word,
  output logic signed [rbd_pkg::WORD_W-1:0]  second_word
);

  logic signed [rbd_pkg::WORD_W-1:0] cells [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [rbd_pkg::WORD_W-1:0] left_word;
    logic signed [rbd_pkg::WORD_W-1:0] right_word;

    if (i == 0) begin : g_first
      assign left_word = word;
    end else begin : g_inner_l
      assign left_word = cells[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_word = '0;
    end else begin : g_inner_r
      assign right_word = cells[i+1];
    end

    rbd_cell #(
      .LEN_W (LEN_W),
      .INDEX (i)
    ) u_cell (
      .clk        (clk),
      .op         (op),
      .len        (len),
      .word       (word),
      .left_word  (left_word),
      .right_word (right_word),
      .data       (cells[i])
    );
  end

  assign head_word   = cells[0];
  assign second_word = cells[1];

endmodule

[rtl/ring_buffer_deque_unit.sv]
// Double-ended queue of signed 32-bit words, up to DEPTH of them.
// Input channel (in_valid / in_stall / in_item) carries one operation per
// item: push front, push back, pop front or pop back. Output channel
// (out_valid / out_stall / out_item) returns one result item per operation:
// status, front and back words (all ones when empty), empty and full flags.
// A push when full or a pop when empty changes nothing and reports a status.
// Storage is two rows of DEPTH cells, one kept in front-to-back order and one
// in back-to-front order, so both ends sit in fixed cells; every operation
// shifts one row by a cell and writes at most one cell of the other, when it changes the deque.
// The result is registered and valid in the cycle after the item is
// accepted. Throughput: one item per cycle while out_stall holds no result;
// the output register is reloaded in the same cycle it is taken.
// When out_stall holds a result, in_stall rises and the deque state holds.
// Reset (rst, synchronous) empties the deque and drops any pending result;
// the word cells themselves are not cleared.
module ring_buffer_deque_unit #(
  parameter int DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  rbd_pkg::in_t  in_item,
  output logic          out_valid,
  input  logic          out_stall,
  output rbd_pkg::out_t out_item
);

  localparam int LEN_W = $clog2(DEPTH + 1);

  logic [LEN_W-1:0]  count;
  logic [LEN_W-1:0]  count_next;
  logic              accept;
  logic              full;
  logic              empty;

  rbd_pkg::cell_op_t op_f_raw, op_b_raw, op_f, op_b;
  rbd_pkg::status_t  status;
  rbd_pkg::out_t     out_next;

  logic signed [rbd_pkg::WORD_W-1:0] f_head, f_second, b_head, b_second;
  logic signed [rbd_pkg::WORD_W-1:0] front_word, back_word;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (count == LEN_W'(DEPTH));
  assign empty    = (count == '0);

  always_comb begin
    op_f_raw   = '0;
    op_b_raw   = '0;
    status     = rbd_pkg::STATUS_DONE;
    count_next = count;
    front_word = f_head;
    back_word  = b_head;
    unique case (in_item.kind)
      rbd_pkg::KIND_PUSH_FRONT: begin
        if (full) begin
          status = rbd_pkg::STATUS_FULL;
        end else begin
          op_f_raw.ins = 1'b1;
          op_b_raw.app = 1'b1;
          count_next   = count + LEN_W'(1);
          front_word   = in_item.value;
          back_word    = empty ? in_item.value : b_head;
        end
      end
      rbd_pkg::KIND_PUSH_BACK: begin
        if (full) begin
          status = rbd_pkg::STATUS_FULL;
        end else begin
          op_b_raw.ins = 1'b1;
          op_f_raw.app = 1'b1;
          count_next   = count + LEN_W'(1);
          back_word    = in_item.value;
          front_word   = empty ? in_item.value : f_head;
        end
      end
      rbd_pkg::KIND_POP_FRONT: begin
        if (empty) begin
          status = rbd_pkg::STATUS_EMPTY;
        end else begin
          op_f_raw.rem = 1'b1;
          count_next   = count - LEN_W'(1);
          front_word   = f_second;
        end
      end
      rbd_pkg::KIND_POP_BACK: begin
        if (empty) begin
          status = rbd_pkg::STATUS_EMPTY;
        end else begin
          op_b_raw.rem = 1'b1;
          count_next   = count - LEN_W'(1);
          back_word    = b_second;
        end
      end
      default: begin
        status = rbd_pkg::STATUS_DONE;
      end
    endcase

    op_f = accept ? op_f_raw : '0;
    op_b = accept ? op_b_raw : '0;

    out_next.status      = status;
    out_next.is_empty    = (count_next == '0);
    out_next.is_full     = (count_next == LEN_W'(DEPTH));
    out_next.front_value = out_next.is_empty ? '1 : front_word;
    out_next.back_value  = out_next.is_empty ? '1 : back_word;
  end

  // Front-to-back row: cell 0 holds the front word.
  rbd_chain #(
    .DEPTH (DEPTH),
    .LEN_W (LEN_W)
  ) u_front_row (
    .clk         (clk),
    .op          (op_f),
    .len         (count),
    .word        (in_item.value),
    .head_word   (f_head),
    .second_word (f_second)
  );

  // Back-to-front row: cell 0 holds the back word.
  rbd_chain #(
    .DEPTH (DEPTH),
    .LEN_W (LEN_W)
  ) u_back_row (
    .clk         (clk),
    .op          (op_b),
    .len         (count),
    .word        (in_item.value),
    .head_word   (b_head),
    .second_word (b_second)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item <= out_next;
    end
  end

endmodule

[sim/rbd_result_check.sv]
module rbd_result_check #(
  parameter int DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_stall,
  input  rbd_pkg::in_t  in_item,
  input  logic          out_valid,
  input  logic          out_stall,
  input  rbd_pkg::out_t out_item,
  output int            mismatches,
  output int            views_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [rbd_pkg::WORD_W-1:0] words [DEPTH];
  int unsigned                       head_idx;
  int unsigned                       tail_idx;
  bit                                empty_now;
  rbd_pkg::out_t                     pending_views[$];

  function automatic bit full_now();
    return !empty_now && ((tail_idx + 1) % DEPTH) == head_idx;
  endfunction

  // Apply one operation to the local deque and return the view it leaves.
  function automatic rbd_pkg::out_t apply_op(rbd_pkg::in_t op);
    rbd_pkg::out_t view;
    view.status = rbd_pkg::STATUS_DONE;
    if (op.kind == rbd_pkg::KIND_PUSH_FRONT || op.kind == rbd_pkg::KIND_PUSH_BACK) begin
      if (empty_now) begin
        head_idx = 0;
        tail_idx = 0;
        words[0] = op.value;
        empty_now = 1'b0;
      end else if (full_now()) begin
        view.status = rbd_pkg::STATUS_FULL;
      end else if (op.kind == rbd_pkg::KIND_PUSH_FRONT) begin
        head_idx = (head_idx + DEPTH - 1) % DEPTH;
        words[head_idx] = op.value;
      end else begin
        tail_idx = (tail_idx + 1) % DEPTH;
        words[tail_idx] = op.value;
      end
    end else begin
      if (empty_now) begin
        view.status = rbd_pkg::STATUS_EMPTY;
      end else if (head_idx == tail_idx) begin
        empty_now = 1'b1;
      end else if (op.kind == rbd_pkg::KIND_POP_FRONT) begin
        head_idx = (head_idx + 1) % DEPTH;
      end else begin
        tail_idx = (tail_idx + DEPTH - 1) % DEPTH;
      end
    end
    view.front_value = empty_now ? '1 : words[head_idx];
    view.back_value  = empty_now ? '1 : words[tail_idx];
    view.is_empty    = empty_now;
    view.is_full     = full_now();
    return view;
  endfunction

  task automatic check_field(string name,
                             logic [rbd_pkg::WORD_W-1:0] want,
                             logic [rbd_pkg::WORD_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $error("%s expected %0h got %0h", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    rbd_pkg::out_t want;
    if (rst) begin
      head_idx = 0;
      tail_idx = 0;
      empty_now = 1'b1;
      mismatches = 0;
      pending_views.delete();
    end else begin
      // Retire the result first so a stray one never pairs with this edge's item.
      if (out_valid && !out_stall) begin
        if (pending_views.size() == 0) begin
          mismatches++;
          $error("result with no operation waiting: %p", out_item);
        end else begin
          want = pending_views[0];
          pending_views.delete(0);
          check_field("status", rbd_pkg::WORD_W'(want.status),
                      rbd_pkg::WORD_W'(out_item.status));
          check_field("front_value", want.front_value, out_item.front_value);
          check_field("back_value", want.back_value, out_item.back_value);
          check_field("is_empty", rbd_pkg::WORD_W'(want.is_empty),
                      rbd_pkg::WORD_W'(out_item.is_empty));
          check_field("is_full", rbd_pkg::WORD_W'(want.is_full),
                      rbd_pkg::WORD_W'(out_item.is_full));
        end
      end
      if (in_valid && !in_stall)
        pending_views.insert(pending_views.size(), apply_op(in_item));
    end
    views_outstanding <= pending_views.size();
  end

endmodule

[sim/ring_buffer_deque_unit_tb.sv]
module ring_buffer_deque_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 16;
  localparam int RANDOM_OPS  = 926;
  localparam int HOLD_CYCLES = 60;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          in_valid  = 1'b0;
  logic          in_stall;
  rbd_pkg::in_t  in_item   = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  rbd_pkg::out_t out_item;

  int    mismatch_count;
  int    views_outstanding;
  int    hold_seq   = 0;
  int    burst_left = 0;

  ring_buffer_deque_unit #(.DEPTH(DEPTH)) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  rbd_result_check #(.DEPTH(DEPTH)) u_check (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_item           (in_item),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_item          (out_item),
    .mismatches        (mismatch_count),
    .views_outstanding (views_outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("ring_buffer_deque_unit_tb: errors");
    $finish;
  end

  // Receiver: stall at a rate drawn anew every run, with one long hold on request.
  initial begin
    int stall_pct;
    int run_len;
    int holds_done;
    holds_done = 0;
    forever begin
      case ($urandom_range(3))
        0: stall_pct = 0;
        1: stall_pct = 20;
        2: stall_pct = 50;
        default: stall_pct = 80;
      endcase
      run_len = $urandom_range(20, 120);
      repeat (run_len) begin
        @(posedge clk);
        if (hold_seq != holds_done) begin
          holds_done = hold_seq;
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic send_op(rbd_pkg::kind_t kind, logic signed [rbd_pkg::WORD_W-1:0] value);
    in_valid <= 1'b1;
    in_item  <= '{kind: kind, value: value};
    do @(posedge clk); while (in_stall);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 30);
    end
  endtask

  // Hold the input idle until every result has come back.
  task automatic wait_for_settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (views_outstanding != 0);
  endtask

  function automatic logic signed [rbd_pkg::WORD_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return {1'b1, {(rbd_pkg::WORD_W-1){1'b0}}};
      1: return {1'b0, {(rbd_pkg::WORD_W-1){1'b1}}};
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int             push_pct;
    int             phase_left;
    rbd_pkg::kind_t kind;
    push_pct = 50;
    phase_left = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Pops on empty, single-word round trips at the value extremes.
    send_op(rbd_pkg::KIND_POP_FRONT, 32'h1234_5678);
    send_op(rbd_pkg::KIND_POP_BACK, 32'h8765_4321);
    send_op(rbd_pkg::KIND_PUSH_BACK, {1'b0, {(rbd_pkg::WORD_W-1){1'b1}}});
    send_op(rbd_pkg::KIND_POP_BACK, '0);
    send_op(rbd_pkg::KIND_PUSH_FRONT, {1'b1, {(rbd_pkg::WORD_W-1){1'b0}}});
    send_op(rbd_pkg::KIND_POP_FRONT, '0);
    // Fill from both ends, then push at each end while full.
    for (int n = 0; n < DEPTH; n++) begin
      kind = n[0] ? rbd_pkg::KIND_PUSH_FRONT : rbd_pkg::KIND_PUSH_BACK;
      send_op(kind, (n == 0) ? '0 : (n == 1) ? '1 : $urandom);
    end
    send_op(rbd_pkg::KIND_PUSH_FRONT, 32'h5555_aaaa);
    send_op(rbd_pkg::KIND_PUSH_BACK, 32'haaaa_5555);
    wait_for_settle();

    for (int i = 0; i < RANDOM_OPS; i++) begin
      if (phase_left == 0) begin
        case ($urandom_range(3))
          0: push_pct = 85;
          1: push_pct = 15;
          2: push_pct = 50;
          default: push_pct = 60;
        endcase
        phase_left = $urandom_range(8, 40);
      end
      phase_left--;
      // Keep offering items through the long receiver hold so the input backs up.
      if (i == 300) begin
        hold_seq++;
        burst_left = 40;
      end
      if (i == 650)
        wait_for_settle();
      if ($urandom_range(99) < push_pct)
        kind = $urandom_range(1) ? rbd_pkg::KIND_PUSH_BACK : rbd_pkg::KIND_PUSH_FRONT;
      else
        kind = $urandom_range(1) ? rbd_pkg::KIND_POP_BACK : rbd_pkg::KIND_POP_FRONT;
      send_op(kind, pick_value());
    end

    wait_for_settle();
    repeat (5) @(posedge clk);
    if (mismatch_count == 0)
      $display("ring_buffer_deque_unit_tb: clean");
    else
      $display("ring_buffer_deque_unit_tb: errors");
    $finish;
  end

endmodule

[sim.f]
rtl/rbd_pkg.sv
rtl/rbd_cell.sv
rtl/rbd_chain.sv
rtl/ring_buffer_deque_unit.sv
sim/rbd_result_check.sv
sim/ring_buffer_deque_unit_tb.sv
